### hdl/mpc_pkg.sv
package mpc_pkg;

    localparam int MAX_LEN     = 1024;
    localparam int ADDR_W      = $clog2(MAX_LEN);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int LEN_W       = CNT_W + 1;
    localparam int COEF_W      = 30;
    localparam int MOD_W       = 31;
    localparam int FUNC_W      = 2;
    localparam int QIDX_W      = 11;
    localparam int STAT_W      = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int BIT_W       = $clog2(COEF_W);

    localparam logic [MOD_W-1:0] MOD_RESET = 31'd998244353;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [FUNC_W-1:0] {
        OP_APPEND_A = 2'd0,
        OP_APPEND_B = 2'd1,
        OP_QUERY    = 2'd2,
        OP_CLEAR    = 2'd3
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [COEF_W-1:0] coef;
        logic [QIDX_W-1:0] qidx;
    } cmd_t;

endpackage

### hdl/mpc_if.sv
interface mpc_item_if import mpc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [COEF_W-1:0] coef_in;
    logic [QIDX_W-1:0] query_index;

    modport source (output valid, func, coef_in, query_index, input ready);
    modport sink   (input valid, func, coef_in, query_index, output ready);
endinterface

interface mpc_result_if import mpc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [COEF_W-1:0] coef_out;
    logic [STAT_W-1:0] status;

    modport source (output valid, coef_out, status, input ready);
    modport sink   (input valid, coef_out, status, output ready);
endinterface

interface mpc_cfg_if import mpc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [MOD_W-1:0] modulus;

    modport source (output valid, modulus, input ready);
    modport sink   (input valid, modulus, output ready);
endinterface

### hdl/mpc_front.sv
module mpc_front import mpc_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    mpc_item_if.sink     items,
    output logic         cmd_valid,
    output cmd_t         cmd,
    input  logic         cmd_pop
);

    cmd_t              queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    cmd_t              new_cmd;
    logic              push;
    logic              pop;

    always_comb
    begin
        new_cmd.op   = op_t'(items.func);
        new_cmd.coef = items.coef_in;
        new_cmd.qidx = items.query_index;
    end

    assign items.ready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign push        = items.valid && items.ready;
    assign cmd_valid   = (count_reg != '0);
    assign pop         = cmd_pop && cmd_valid;
    assign cmd         = queue_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= new_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

### hdl/mpc_mulmod.sv
module mpc_mulmod import mpc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [COEF_W-1:0] x,
    input  logic [COEF_W-1:0] y,
    input  logic [MOD_W-1:0]  m,
    output logic              done,
    output logic [MOD_W-1:0]  prod
);

    typedef enum logic [1:0] {
        M_IDLE,
        M_REDUCE,
        M_MULT
    } mstate_t;

    mstate_t           state_reg;
    logic [COEF_W-1:0] x_reg;
    logic [COEF_W-1:0] y_reg;
    logic [MOD_W-1:0]  xr_reg;
    logic [MOD_W-1:0]  r_reg;
    logic [BIT_W-1:0]  bit_reg;
    logic              done_reg;

    logic [MOD_W:0]    mx;
    logic [MOD_W:0]    shifted;
    logic [MOD_W:0]    red;
    logic [MOD_W:0]    dbl;
    logic [MOD_W:0]    d1;
    logic [MOD_W:0]    sum;
    logic [MOD_W:0]    s1;

    // restoring reduction of x, then double-and-add over the bits of y
    always_comb
    begin
        mx      = {1'b0, m};
        shifted = {r_reg, x_reg[bit_reg]};
        red     = (shifted >= mx) ? shifted - mx : shifted;
        dbl     = {r_reg, 1'b0};
        d1      = (dbl >= mx) ? dbl - mx : dbl;
        sum     = d1 + (y_reg[bit_reg] ? {1'b0, xr_reg} : '0);
        s1      = (sum >= mx) ? sum - mx : sum;
    end

    assign done = done_reg;
    assign prod = r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            x_reg     <= '0;
            y_reg     <= '0;
            xr_reg    <= '0;
            r_reg     <= '0;
            bit_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == M_MULT) && (bit_reg == '0);
            unique case (state_reg)
                M_IDLE:
                begin
                    if (start)
                    begin
                        x_reg     <= x;
                        y_reg     <= y;
                        r_reg     <= '0;
                        bit_reg   <= BIT_W'(COEF_W - 1);
                        state_reg <= M_REDUCE;
                    end
                end
                M_REDUCE:
                begin
                    if (bit_reg == '0)
                    begin
                        xr_reg    <= red[MOD_W-1:0];
                        r_reg     <= '0;
                        bit_reg   <= BIT_W'(COEF_W - 1);
                        state_reg <= M_MULT;
                    end
                    else
                    begin
                        r_reg   <= red[MOD_W-1:0];
                        bit_reg <= bit_reg - 1'b1;
                    end
                end
                M_MULT:
                begin
                    r_reg <= s1[MOD_W-1:0];
                    if (bit_reg == '0)
                    begin
                        state_reg <= M_IDLE;
                    end
                    else
                    begin
                        bit_reg <= bit_reg - 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

endmodule

### hdl/mpc_back.sv
module mpc_back import mpc_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  cmd_t          cmd,
    output logic          cmd_pop,
    mpc_cfg_if.sink       cfg,
    mpc_result_if.source  results
);

    typedef enum logic [2:0] {
        B_IDLE,
        B_READ,
        B_MSTART,
        B_MWAIT,
        B_DONE
    } bstate_t;

    logic [COEF_W-1:0] first_mem  [MAX_LEN];
    logic [COEF_W-1:0] second_mem [MAX_LEN];

    bstate_t           state_reg;
    logic [MOD_W-1:0]  mod_reg;
    logic [CNT_W-1:0]  fc_reg;
    logic [CNT_W-1:0]  sc_reg;
    logic [QIDX_W-1:0] k_reg;
    logic [ADDR_W-1:0] i_reg;
    logic [ADDR_W-1:0] hi_reg;
    logic [MOD_W-1:0]  acc_reg;
    logic [COEF_W-1:0] a_rd_reg;
    logic [COEF_W-1:0] b_rd_reg;
    logic [COEF_W-1:0] pend_coef_reg;
    logic [STAT_W-1:0] pend_status_reg;
    logic              out_valid_reg;
    logic [COEF_W-1:0] out_coef_reg;
    logic [STAT_W-1:0] out_status_reg;

    logic              a_full;
    logic              b_full;
    logic              q_bad;
    logic [LEN_W-1:0]  k_ext;
    logic [LEN_W-1:0]  kp1;
    logic [LEN_W-1:0]  fc_ext;
    logic [LEN_W-1:0]  sc_ext;
    logic [LEN_W-1:0]  lo_full;
    logic [LEN_W-1:0]  hi_full;
    logic [LEN_W-1:0]  j_full;
    logic [MOD_W:0]    acc_sum;
    logic [MOD_W:0]    acc_red;
    logic              out_free;
    logic              out_load;
    logic              take;
    logic              mul_start;
    logic              mul_done;
    logic [MOD_W-1:0]  mul_prod;

    always_comb
    begin
        a_full  = (fc_reg == CNT_W'(MAX_LEN));
        b_full  = (sc_reg == CNT_W'(MAX_LEN));
        k_ext   = LEN_W'(cmd.qidx);
        kp1     = k_ext + 1'b1;
        fc_ext  = LEN_W'(fc_reg);
        sc_ext  = LEN_W'(sc_reg);
        q_bad   = (fc_reg == '0) || (sc_reg == '0) || (k_ext >= fc_ext + sc_ext - 1'b1);
        lo_full = (kp1 > sc_ext) ? kp1 - sc_ext : '0;
        hi_full = (k_ext < fc_ext - 1'b1) ? k_ext : fc_ext - 1'b1;
        j_full  = LEN_W'(k_reg) - LEN_W'(i_reg);
        acc_sum = {1'b0, acc_reg} + {1'b0, mul_prod};
        acc_red = (acc_sum >= {1'b0, mod_reg}) ? acc_sum - {1'b0, mod_reg} : acc_sum;
    end

    assign take             = (state_reg == B_IDLE) && cmd_valid;
    assign cmd_pop          = take;
    assign mul_start        = (state_reg == B_MSTART);
    assign out_free         = !out_valid_reg || results.ready;
    assign out_load         = (state_reg == B_DONE) && out_free;
    assign cfg.ready        = 1'b1;
    assign results.valid    = out_valid_reg;
    assign results.coef_out = out_coef_reg;
    assign results.status   = out_status_reg;

    mpc_mulmod u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .x     (a_rd_reg),
        .y     (b_rd_reg),
        .m     (mod_reg),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    always_ff @(posedge clk)
    begin
        if (take && (cmd.op == OP_APPEND_A) && !a_full)
        begin
            first_mem[fc_reg[ADDR_W-1:0]] <= cmd.coef;
        end
        if (take && (cmd.op == OP_APPEND_B) && !b_full)
        begin
            second_mem[sc_reg[ADDR_W-1:0]] <= cmd.coef;
        end
        if (state_reg == B_READ)
        begin
            a_rd_reg <= first_mem[i_reg];
            b_rd_reg <= second_mem[j_full[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= B_IDLE;
            mod_reg         <= MOD_RESET;
            fc_reg          <= '0;
            sc_reg          <= '0;
            k_reg           <= '0;
            i_reg           <= '0;
            hi_reg          <= '0;
            acc_reg         <= '0;
            pend_coef_reg   <= '0;
            pend_status_reg <= ST_OK;
            out_valid_reg   <= 1'b0;
            out_coef_reg    <= '0;
            out_status_reg  <= ST_OK;
        end
        else
        begin
            if (cfg.valid)
            begin
                mod_reg <= cfg.modulus;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        pend_coef_reg <= '0;
                        unique case (cmd.op)
                            OP_APPEND_A:
                            begin
                                pend_status_reg <= a_full ? ST_FULL : ST_OK;
                                if (!a_full)
                                begin
                                    fc_reg <= fc_reg + 1'b1;
                                end
                                state_reg <= B_DONE;
                            end
                            OP_APPEND_B:
                            begin
                                pend_status_reg <= b_full ? ST_FULL : ST_OK;
                                if (!b_full)
                                begin
                                    sc_reg <= sc_reg + 1'b1;
                                end
                                state_reg <= B_DONE;
                            end
                            OP_QUERY:
                            begin
                                pend_status_reg <= q_bad ? ST_RANGE : ST_OK;
                                if (!q_bad && (mod_reg >= MOD_W'(2)))
                                begin
                                    k_reg     <= cmd.qidx;
                                    i_reg     <= lo_full[ADDR_W-1:0];
                                    hi_reg    <= hi_full[ADDR_W-1:0];
                                    acc_reg   <= '0;
                                    state_reg <= B_READ;
                                end
                                else
                                begin
                                    state_reg <= B_DONE;
                                end
                            end
                            OP_CLEAR:
                            begin
                                fc_reg          <= '0;
                                sc_reg          <= '0;
                                pend_status_reg <= ST_OK;
                                state_reg       <= B_DONE;
                            end
                            default:
                            begin
                                pend_status_reg <= ST_OK;
                                state_reg       <= B_DONE;
                            end
                        endcase
                    end
                end
                B_READ:
                begin
                    state_reg <= B_MSTART;
                end
                B_MSTART:
                begin
                    state_reg <= B_MWAIT;
                end
                B_MWAIT:
                begin
                    if (mul_done)
                    begin
                        acc_reg <= acc_red[MOD_W-1:0];
                        if (i_reg == hi_reg)
                        begin
                            pend_coef_reg <= acc_red[COEF_W-1:0];
                            state_reg     <= B_DONE;
                        end
                        else
                        begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= B_READ;
                        end
                    end
                end
                B_DONE:
                begin
                    if (out_free)
                    begin
                        out_coef_reg   <= pend_coef_reg;
                        out_status_reg <= pend_status_reg;
                        state_reg      <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (fc_reg <= CNT_W'(MAX_LEN)) && (sc_reg <= CNT_W'(MAX_LEN)))
        else $error("sequence count beyond capacity");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_READ) |-> (i_reg <= hi_reg))
        else $error("product index past upper bound");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != ST_OK)) |-> (out_coef_reg == '0))
        else $error("nonzero coefficient with error status");

    a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_MWAIT) |-> (acc_reg < mod_reg))
        else $error("accumulator not reduced");

endmodule

### hdl/modular_polynomial_convolution.sv
// channel   dir   payload                        transfer when
// items     in    func, coef_in, query_index     items.valid & items.ready
// results   out   coef_out, status               results.valid & results.ready
// cfg       in    modulus                        cfg.valid & cfg.ready (always ready)
//
// Append and clear: the back end passes from idle to done once queued.
// Query: per product term the back end reads, starts the multiplier and waits on it
// (30 reduce steps, 30 multiply steps, done) in the serial multiplier, up to 1024 terms.
// Reset clears counts, queue and output; stores need no clear.
// A two-entry queue takes items while the back end works or holds a result, until it is full.
module modular_polynomial_convolution import mpc_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    mpc_item_if.sink      items,
    mpc_result_if.source  results,
    mpc_cfg_if.sink       cfg
);

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;

    mpc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    mpc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .cfg       (cfg),
        .results   (results)
    );

endmodule
